@@ hdl/smpq_pkg.sv @@
// Shared types and codes for the sorted max priority queue.
// Field widths, command and status codes, transfer payload structs.
// No dependencies.
package smpq_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int VALUE_BITS = 32;
	localparam int TAG_BITS   = 8;
	localparam int OCC_BITS   = 5;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_POP    = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                  cmd;
		logic [VALUE_BITS-1:0] entry_value;
		logic [TAG_BITS-1:0]   entry_tag;
	} smpq_req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [VALUE_BITS-1:0] out_value;
		logic [TAG_BITS-1:0]   out_tag;
		logic [OCC_BITS-1:0]   occupancy;
	} smpq_rsp_t;

	// one stored entry as kept in the RAM
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [TAG_BITS-1:0]   tag;
	} smpq_entry_t;

endpackage

@@ hdl/smpq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies; contents are not reset.
module smpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/sorted_max_priority_queue.sv @@
// Sorted max priority queue: entries kept in a RAM ring, descending by value.
// Pop reads the head entry and answers from ST_POP. Full/empty rejects and insert into empty
// answer straight from idle. Other inserts: the backward compare-and-shift walk reads one
// entry per cycle from the single RAM read port. Ties leave first in, first out.
// Reset (arst_n low) empties the queue at once; RAM contents are not cleared.
// done pulses for one cycle with result; the next transfer can be taken then.
module sorted_max_priority_queue #(
	parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  smpq_pkg::smpq_req_t req,
	output logic                done,
	output smpq_pkg::smpq_rsp_t result
);
	import smpq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int ENT_W = $bits(smpq_entry_t);

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_POP      = 2'd1;
	localparam logic [1:0] ST_INS      = 2'd2;
	localparam logic [1:0] ST_INS_LAST = 2'd3;

	logic [1:0]              state_q;
	logic [PTR_W-1:0]        head_q;
	logic [CNT_W-1:0]        fill_q;
	logic [PTR_W-1:0]        hole_q;
	logic [PTR_W-1:0]        cur_q;
	logic [CNT_W-1:0]        left_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [TAG_BITS-1:0]     tag_q;
	logic                    done_q;
	smpq_rsp_t               result_q;

	logic                    accept;
	logic                    wr_en;
	logic [PTR_W-1:0]        wr_addr;
	smpq_entry_t             wr_entry;
	logic                    rd_en;
	logic [PTR_W-1:0]        rd_addr;
	logic [ENT_W-1:0]        rd_data;
	smpq_entry_t             rd_entry;
	logic [SUM_W-1:0]        tail_sum;
	logic [PTR_W-1:0]        tail;
	logic                    stop_here;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST_PTR : p - PTR_W'(1);
	endfunction

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign rd_entry = smpq_entry_t'(rd_data);

	// first free slot of the ring; fill < DEPTH whenever it is used
	assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
	assign tail     = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);

	// new entry goes behind the stored one just read
	assign stop_here = (rd_entry.value >= val_q);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = hole_q;
		wr_entry = '{value: val_q, tag: tag_q};
		rd_en    = 1'b0;
		rd_addr  = head_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_POP) begin
						rd_en = (fill_q != '0);
					end else if (fill_q == '0) begin
						wr_en    = 1'b1;
						wr_addr  = head_q;
						wr_entry = '{value: req.entry_value, tag: req.entry_tag};
					end else if (fill_q != FULL_CNT) begin
						rd_en   = 1'b1;
						rd_addr = ptr_dec(tail);
					end
				end
			end
			ST_INS: begin
				wr_en = 1'b1;
				if (!stop_here) begin
					wr_entry = rd_entry;
					if (left_q != CNT_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = ptr_dec(cur_q);
					end
				end
			end
			ST_INS_LAST: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	smpq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (ENT_W'(wr_entry)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.cmd == CMD_POP) begin
							if (fill_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q <= ST_POP;
							end
						end else if (fill_q == FULL_CNT) begin
							done_q <= 1'b1;
						end else if (fill_q == '0) begin
							fill_q <= CNT_W'(1);
							done_q <= 1'b1;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_POP: begin
					head_q  <= ptr_inc(head_q);
					fill_q  <= fill_q - CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_INS: begin
					if (stop_here) begin
						fill_q  <= fill_q + CNT_W'(1);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (left_q == CNT_W'(1)) begin
						state_q <= ST_INS_LAST;
					end
				end
				ST_INS_LAST: begin
					fill_q  <= fill_q + CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk pointers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				val_q  <= req.entry_value;
				tag_q  <= req.entry_tag;
				hole_q <= tail;
				cur_q  <= ptr_dec(tail);
				left_q <= fill_q;
				result_q.out_value <= '0;
				result_q.out_tag   <= '0;
				if (req.cmd == CMD_POP) begin
					result_q.status    <= STATUS_EMPTY;
					result_q.occupancy <= OCC_BITS'(fill_q);
				end else if (fill_q == FULL_CNT) begin
					result_q.status    <= STATUS_FULL;
					result_q.occupancy <= OCC_BITS'(fill_q);
				end else begin
					result_q.status    <= STATUS_OK;
					result_q.occupancy <= OCC_BITS'(fill_q + CNT_W'(1));
				end
			end
			ST_POP: begin
				result_q.status    <= STATUS_OK;
				result_q.out_value <= rd_entry.value;
				result_q.out_tag   <= rd_entry.tag;
				result_q.occupancy <= OCC_BITS'(fill_q - CNT_W'(1));
			end
			ST_INS: begin
				if (!stop_here) begin
					hole_q <= cur_q;
					cur_q  <= ptr_dec(cur_q);
					left_q <= left_q - CNT_W'(1);
				end
			end
			ST_INS_LAST: begin
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ hdl/smpq_checker.sv @@
// Port-level checks for the sorted max priority queue, bound to the top level.
// Depends on smpq_pkg for payload types and status codes.
module smpq_assertions #(
	parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input smpq_pkg::smpq_rsp_t result
);
	import smpq_pkg::*;

	// every accepted transfer is either answered next cycle or still in work
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transfer neither answered nor busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STATUS_OK) |->
		(result.out_value == '0 && result.out_tag == '0))
		else $error("rejected transfer carries payload");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_EMPTY) |-> (result.occupancy == '0))
		else $error("empty status with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STATUS_FULL) |-> (result.occupancy == OCC_BITS'(DEPTH)))
		else $error("full status with occupancy below depth");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occupancy <= OCC_BITS'(DEPTH)))
		else $error("occupancy above depth");

endmodule

bind sorted_max_priority_queue smpq_assertions #(
	.DEPTH (DEPTH)
) u_smpq_assertions (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
